@@ rtl/smtc_pkg.sv @@
package smtc_pkg;

  localparam int TICK_W     = 32;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int TIMEOUT_W  = 20;
  localparam int DEBOUNCE_W = 16;
  localparam int LONG_W     = 16;
  localparam int COOLDOWN_W = 20;

  localparam logic [MODE_W-1:0] MODE_OFF     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOCAL   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_NETWORK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_NETWORK_TIMEOUT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MOTION_COOLDOWN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STANDALONE_EN   = 3'd4;

  localparam logic [TIMEOUT_W-1:0]  RST_NETWORK_TIMEOUT = 20'd5000;
  localparam logic [DEBOUNCE_W-1:0] RST_DEBOUNCE        = 16'd50;
  localparam logic [LONG_W-1:0]     RST_LONG_PRESS      = 16'd3000;
  localparam logic [COOLDOWN_W-1:0] RST_MOTION_COOLDOWN = 20'd30000;

  typedef struct packed {
    logic packet_seen;
    logic button_raw;
    logic motion_level;
    logic playback_busy;
  } item_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode_now;
    logic              start_pulse;
    logic              stop_pulse;
    logic              network_active;
    logic              lamp_on;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_t;

endpackage

@@ rtl/smtc_stream_if.sv @@
interface smtc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/show_mode_trigger_controller.sv @@
// each result word is registered in the cycle after its item word is taken
// throughput: one item per cycle; the item side stalls only while the result
// register is full and the result side is not ready
// all tick state updates in one pass through short compares and 32-bit subtracts
// reset: rst is synchronous, active high; clears tick state and mode, empties the
// result register, and loads the register defaults
module show_mode_trigger_controller (
  input logic          clk,
  input logic          rst,
  smtc_stream_if.sink   item,
  smtc_stream_if.source result,
  smtc_stream_if.sink   cfg
);
  import smtc_pkg::*;

  // configuration registers
  logic [TIMEOUT_W-1:0]  network_timeout_ms;
  logic [DEBOUNCE_W-1:0] debounce_ms;
  logic [LONG_W-1:0]     long_press_ms;
  logic [COOLDOWN_W-1:0] motion_cooldown_ms;
  logic                  standalone_enable;

  // tick state
  logic [TICK_W-1:0] tick_clock;
  logic [TICK_W-1:0] last_packet_tick, last_packet_tick_next;
  logic              packet_ever_seen, packet_ever_seen_next;
  logic [MODE_W-1:0] ctl_mode, ctl_mode_next;
  logic              button_pressed, button_pressed_next;
  logic [TICK_W-1:0] last_change_tick, last_change_tick_next;
  logic [TICK_W-1:0] press_start_tick, press_start_tick_next;
  logic              long_press_done, long_press_done_next;
  logic              motion_previous, motion_previous_next;
  logic [TICK_W-1:0] last_motion_tick, last_motion_tick_next;

  logic    out_valid;
  result_t out_data;
  result_t res_next;

  item_t             it;
  logic              accept;
  logic [TICK_W-1:0] now;
  logic              pressed;
  logic              net;
  logic              bounce;
  logic              start_any, stop_any;
  logic [MODE_W-1:0] m1, m2, m3;
  logic [TICK_W-1:0] held;

  assign it     = item.data;
  assign accept = item.valid && item.ready;
  assign now    = tick_clock;
  assign pressed = ~it.button_raw;

  assign item.ready   = !out_valid || result.ready;
  assign result.valid = out_valid;
  assign result.data  = out_data;
  assign cfg.ready    = 1'b1;

  always_comb begin
    last_packet_tick_next = last_packet_tick;
    packet_ever_seen_next = packet_ever_seen;
    button_pressed_next   = button_pressed;
    last_change_tick_next = last_change_tick;
    press_start_tick_next = press_start_tick;
    long_press_done_next  = long_press_done;
    motion_previous_next  = motion_previous;
    last_motion_tick_next = last_motion_tick;
    start_any = 1'b0;
    stop_any  = 1'b0;
    bounce    = 1'b0;
    held      = now - press_start_tick;

    if (it.packet_seen) begin
      last_packet_tick_next = now;
      packet_ever_seen_next = 1'b1;
    end
    net = packet_ever_seen_next &&
          ((now - last_packet_tick_next) < {{(TICK_W-TIMEOUT_W){1'b0}}, network_timeout_ms});

    m1 = ctl_mode;
    if (net) begin
      if (ctl_mode == MODE_LOCAL) stop_any = 1'b1;
      m1 = MODE_NETWORK;
    end else if (ctl_mode == MODE_NETWORK) begin
      m1 = MODE_OFF;
    end else if (ctl_mode == MODE_LOCAL && !it.playback_busy) begin
      stop_any = 1'b1;
      m1 = MODE_OFF;
    end

    m2 = m1;
    m3 = m1;
    ctl_mode_next = m1;
    if (m1 != MODE_NETWORK) begin
      // button: a change inside the debounce window drops the whole button pass
      if (pressed != button_pressed) begin
        if ((now - last_change_tick) < {{(TICK_W-DEBOUNCE_W){1'b0}}, debounce_ms}) begin
          bounce = 1'b1;
        end else begin
          last_change_tick_next = now;
        end
      end
      if (!bounce) begin
        if (pressed && !button_pressed) begin
          press_start_tick_next = now;
          long_press_done_next  = 1'b0;
        end
        // short press on release
        if (!pressed && button_pressed) begin
          if (held < {{(TICK_W-LONG_W){1'b0}}, long_press_ms} && !long_press_done) begin
            if (m1 == MODE_LOCAL) begin
              stop_any = 1'b1;
              m2 = MODE_OFF;
            end else if (standalone_enable) begin
              start_any = 1'b1;
              m2 = MODE_LOCAL;
            end
          end
        end
        m3 = m2;
        // long press while held, once per press
        if (pressed && !long_press_done_next) begin
          if ((now - press_start_tick_next) > {{(TICK_W-LONG_W){1'b0}}, long_press_ms}) begin
            long_press_done_next = 1'b1;
            stop_any = 1'b1;
            m3 = MODE_OFF;
          end
        end
        button_pressed_next = pressed;
      end

      ctl_mode_next = m3;
      if (it.motion_level && !motion_previous) begin
        if ((now - last_motion_tick) >
            {{(TICK_W-COOLDOWN_W){1'b0}}, motion_cooldown_ms}) begin
          last_motion_tick_next = now;
          if (m3 != MODE_LOCAL && standalone_enable) begin
            start_any = 1'b1;
            ctl_mode_next = MODE_LOCAL;
          end
        end
      end
      motion_previous_next = it.motion_level;
    end

    res_next.mode_now       = ctl_mode_next;
    res_next.start_pulse    = start_any;
    res_next.stop_pulse     = stop_any;
    res_next.network_active = net;
    res_next.lamp_on        = (ctl_mode_next == MODE_LOCAL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_clock       <= '0;
      last_packet_tick <= '0;
      packet_ever_seen <= 1'b0;
      ctl_mode         <= MODE_OFF;
      button_pressed   <= 1'b0;
      last_change_tick <= '0;
      press_start_tick <= '0;
      long_press_done  <= 1'b0;
      motion_previous  <= 1'b0;
      last_motion_tick <= '0;
    end else if (accept) begin
      tick_clock       <= now + TICK_W'(1);
      last_packet_tick <= last_packet_tick_next;
      packet_ever_seen <= packet_ever_seen_next;
      ctl_mode         <= ctl_mode_next;
      button_pressed   <= button_pressed_next;
      last_change_tick <= last_change_tick_next;
      press_start_tick <= press_start_tick_next;
      long_press_done  <= long_press_done_next;
      motion_previous  <= motion_previous_next;
      last_motion_tick <= last_motion_tick_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      network_timeout_ms <= RST_NETWORK_TIMEOUT;
      debounce_ms        <= RST_DEBOUNCE;
      long_press_ms      <= RST_LONG_PRESS;
      motion_cooldown_ms <= RST_MOTION_COOLDOWN;
      standalone_enable  <= 1'b1;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.data.index)
        REG_NETWORK_TIMEOUT: network_timeout_ms <= cfg.data.value[TIMEOUT_W-1:0];
        REG_DEBOUNCE:        debounce_ms        <= cfg.data.value[DEBOUNCE_W-1:0];
        REG_LONG_PRESS:      long_press_ms      <= cfg.data.value[LONG_W-1:0];
        REG_MOTION_COOLDOWN: motion_cooldown_ms <= cfg.data.value[COOLDOWN_W-1:0];
        REG_STANDALONE_EN:   standalone_enable  <= cfg.data.value[0];
        default: ;
      endcase
    end
  end

endmodule

@@ test/show_mode_trigger_controller_tb.sv @@
module show_mode_trigger_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import smtc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;
  localparam logic [CFG_DATA_W-1:0] CFG_ALL_ONES = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;

  smtc_stream_if #(.payload_t(item_t))   item_if ();
  smtc_stream_if #(.payload_t(result_t)) result_if ();
  smtc_stream_if #(.payload_t(cfg_t))    cfg_if ();

  show_mode_trigger_controller u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the controller: register settings and tick state
  logic [TIMEOUT_W-1:0]  cfg_timeout;
  logic [DEBOUNCE_W-1:0] cfg_debounce;
  logic [LONG_W-1:0]     cfg_long;
  logic [COOLDOWN_W-1:0] cfg_cooldown;
  logic                  cfg_enable;

  logic [TICK_W-1:0] tick_now;
  logic [TICK_W-1:0] last_pkt_tick;
  logic [TICK_W-1:0] last_change_tick;
  logic [TICK_W-1:0] press_start_tick;
  logic [TICK_W-1:0] last_motion_tick;
  logic              pkt_ever;
  logic              btn_down;
  logic              long_done;
  logic              motion_prev;
  logic [MODE_W-1:0] show_mode;

  item_t   item_queue[$];
  result_t show_results_due[$];

  int items_taken;
  int results_checked;
  int err_count;
  int starts_seen;
  int stops_seen;
  int net_ticks;
  int settings_used;
  int burst_left;
  int gap_left;
  int hold_at;
  logic long_hold;
  logic [9:0] rx_cycle = '0;
  result_t want_res;
  result_t got_res;

  task automatic reset_show_state();
    cfg_timeout      = RST_NETWORK_TIMEOUT;
    cfg_debounce     = RST_DEBOUNCE;
    cfg_long         = RST_LONG_PRESS;
    cfg_cooldown     = RST_MOTION_COOLDOWN;
    cfg_enable       = 1'b1;
    tick_now         = '0;
    last_pkt_tick    = '0;
    last_change_tick = '0;
    press_start_tick = '0;
    last_motion_tick = '0;
    pkt_ever         = 1'b0;
    btn_down         = 1'b0;
    long_done        = 1'b0;
    motion_prev      = 1'b0;
    show_mode        = MODE_OFF;
  endtask

  function automatic result_t next_show_result(input item_t it);
    logic [TICK_W-1:0] now;
    logic              pressed;
    logic              net;
    logic              start_f;
    logic              stop_f;
    logic              bounced;
    result_t           res;
    now     = tick_now;
    pressed = ~it.button_raw;
    start_f = 1'b0;
    stop_f  = 1'b0;
    bounced = 1'b0;
    if (it.packet_seen) begin
      last_pkt_tick = now;
      pkt_ever = 1'b1;
    end
    net = pkt_ever && ((now - last_pkt_tick) < cfg_timeout);
    if (net) begin
      if (show_mode == MODE_LOCAL) stop_f = 1'b1;
      show_mode = MODE_NETWORK;
    end else if (show_mode == MODE_NETWORK) begin
      show_mode = MODE_OFF;
    end else if (show_mode == MODE_LOCAL && !it.playback_busy) begin
      stop_f = 1'b1;
      show_mode = MODE_OFF;
    end
    // button and motion are frozen under network control
    if (show_mode != MODE_NETWORK) begin
      if (pressed != btn_down) begin
        if ((now - last_change_tick) < cfg_debounce) bounced = 1'b1;
        else last_change_tick = now;
      end
      if (!bounced) begin
        if (pressed && !btn_down) begin
          press_start_tick = now;
          long_done = 1'b0;
        end
        if (!pressed && btn_down && !long_done && (now - press_start_tick) < cfg_long) begin
          if (show_mode == MODE_LOCAL) begin
            stop_f = 1'b1;
            show_mode = MODE_OFF;
          end else if (cfg_enable) begin
            start_f = 1'b1;
            show_mode = MODE_LOCAL;
          end
        end
        if (pressed && !long_done && (now - press_start_tick) > cfg_long) begin
          long_done = 1'b1;
          stop_f = 1'b1;
          show_mode = MODE_OFF;
        end
        btn_down = pressed;
      end
      if (it.motion_level && !motion_prev && (now - last_motion_tick) > cfg_cooldown) begin
        last_motion_tick = now;
        if (show_mode != MODE_LOCAL && cfg_enable) begin
          start_f = 1'b1;
          show_mode = MODE_LOCAL;
        end
      end
      motion_prev = it.motion_level;
    end
    tick_now = now + 1;
    res.mode_now       = show_mode;
    res.start_pulse    = start_f;
    res.stop_pulse     = stop_f;
    res.network_active = net;
    res.lamp_on        = (show_mode == MODE_LOCAL);
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    $display("mismatch at result word %0d: %s", results_checked, what);
  endtask

  // item side: bursts of random length with random gaps
  always @(posedge clk) begin
    if (rst) begin
      item_if.valid <= 1'b0;
    end else begin
      if (item_if.valid && item_if.ready) begin
        show_results_due.insert(show_results_due.size(),
                                next_show_result(item_if.data));
        items_taken++;
      end
      if (!item_if.valid || item_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          item_if.valid <= 1'b0;
        end else if (item_queue.size() > 0) begin
          item_if.data  <= item_queue.pop_front();
          item_if.valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          item_if.valid <= 1'b0;
        end
      end
    end
  end

  // result side: stall pattern changes with bits 9:8 of a free-running counter
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 10'd1;
    case (rx_cycle[9:8])
      2'd0: begin
        result_if.ready <= !long_hold;
      end
      2'd1: begin
        result_if.ready <= !long_hold && ($urandom_range(0, 3) != 0);
      end
      2'd2: begin
        result_if.ready <= !long_hold && rx_cycle[0];
      end
      default: begin
        result_if.ready <= !long_hold && ($urandom_range(0, 1) != 0);
      end
    endcase
  end

  // one long hold-off on the result side while items keep coming
  initial begin
    long_hold = 1'b0;
    wait (hold_at != 0 && items_taken >= hold_at);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (400) @(posedge clk);
    long_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) begin
      got_res = result_if.data;
      if (show_results_due.size() == 0) begin
        report_mismatch("result word with no tick pending");
      end else begin
        want_res = show_results_due.pop_front();
        if (got_res.mode_now !== want_res.mode_now)
          report_mismatch($sformatf("mode_now got %0d want %0d",
                                    got_res.mode_now, want_res.mode_now));
        if (got_res.start_pulse !== want_res.start_pulse)
          report_mismatch($sformatf("start_pulse got %b want %b",
                                    got_res.start_pulse, want_res.start_pulse));
        if (got_res.stop_pulse !== want_res.stop_pulse)
          report_mismatch($sformatf("stop_pulse got %b want %b",
                                    got_res.stop_pulse, want_res.stop_pulse));
        if (got_res.network_active !== want_res.network_active)
          report_mismatch($sformatf("network_active got %b want %b",
                                    got_res.network_active, want_res.network_active));
        if (got_res.lamp_on !== want_res.lamp_on)
          report_mismatch($sformatf("lamp_on got %b want %b",
                                    got_res.lamp_on, want_res.lamp_on));
        starts_seen += want_res.start_pulse;
        stops_seen  += want_res.stop_pulse;
        net_ticks   += want_res.network_active;
      end
      results_checked++;
    end
  end

  task automatic push_item(input logic pkt, input logic btn, input logic mot, input logic busy);
    item_t it;
    it.packet_seen   = pkt;
    it.button_raw    = btn;
    it.motion_level  = mot;
    it.playback_busy = busy;
    item_queue.insert(item_queue.size(), it);
  endtask

  // called at a clock edge; leaves cfg valid high until the caller lowers it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_t w;
    w.index = idx;
    w.value = val;
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= w;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      REG_NETWORK_TIMEOUT: cfg_timeout  = val[TIMEOUT_W-1:0];
      REG_DEBOUNCE:        cfg_debounce = val[DEBOUNCE_W-1:0];
      REG_LONG_PRESS:      cfg_long     = val[LONG_W-1:0];
      REG_MOTION_COOLDOWN: cfg_cooldown = val[COOLDOWN_W-1:0];
      REG_STANDALONE_EN:   cfg_enable   = val[0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] timeout,
                              input logic [CFG_DATA_W-1:0] debounce,
                              input logic [CFG_DATA_W-1:0] long_ms,
                              input logic [CFG_DATA_W-1:0] cooldown,
                              input logic [CFG_DATA_W-1:0] enable);
    write_reg(REG_NETWORK_TIMEOUT, timeout);
    write_reg(REG_DEBOUNCE, debounce);
    write_reg(REG_LONG_PRESS, long_ms);
    write_reg(REG_MOTION_COOLDOWN, cooldown);
    write_reg(REG_STANDALONE_EN, enable);
    cfg_if.valid <= 1'b0;
    settings_used++;
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (item_queue.size() != 0 || show_results_due.size() != 0 || item_if.valid)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // mostly held presses, motion runs and occasional packets, some pure noise
  task automatic gen_ticks(input int n);
    logic btn;
    logic mot;
    int   btn_run;
    int   mot_run;
    int   press_max;
    btn = 1'b1;
    mot = 1'b0;
    btn_run = $urandom_range(1, 6);
    mot_run = $urandom_range(1, 10);
    press_max = (cfg_long < 12) ? cfg_long + 4 : 16;
    repeat (n) begin
      if (btn_run == 0) begin
        btn = ~btn;
        btn_run = btn ? $urandom_range(1, 8) : $urandom_range(1, press_max);
      end
      if (mot_run == 0) begin
        mot = ~mot;
        mot_run = $urandom_range(1, 10);
      end
      btn_run--;
      mot_run--;
      if ($urandom_range(0, 9) == 0)
        item_queue.insert(item_queue.size(), item_t'(4'($urandom)));
      else
        push_item($urandom_range(0, 24) == 0, btn, mot, $urandom_range(0, 9) != 0);
    end
  endtask

  initial begin
    item_if.valid   = 1'b0;
    item_if.data    = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.data     = '0;
    result_if.ready = 1'b0;
    items_taken = 0;
    results_checked = 0;
    err_count = 0;
    starts_seen = 0;
    stops_seen = 0;
    net_ticks = 0;
    settings_used = 0;
    burst_left = 0;
    gap_left = 0;
    hold_at = 0;
    reset_show_state();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults: press inside debounce, motion inside reset cooldown, packet takes over
    push_item(1'b0, 1'b1, 1'b0, 1'b0);
    push_item(1'b0, 1'b0, 1'b1, 1'b0);
    push_item(1'b0, 1'b1, 1'b0, 1'b1);
    push_item(1'b1, 1'b0, 1'b1, 1'b1);
    push_item(1'b0, 1'b1, 1'b0, 1'b0);
    wait_idle();

    write_reg(REG_UNUSED_LO, CFG_ALL_ONES);
    write_reg(REG_UNUSED_HI, 20'h0);
    program_regs(20'd2, 20'hF0000, 20'h30003, 20'd0, 20'hFFFF1);
    push_item(1'b0, 1'b1, 1'b0, 1'b1);
    // short press starts, next short press stops
    push_item(1'b0, 1'b0, 1'b0, 1'b1);
    push_item(1'b0, 1'b1, 1'b0, 1'b1);
    push_item(1'b0, 1'b1, 1'b0, 1'b1);
    push_item(1'b0, 1'b0, 1'b0, 1'b1);
    push_item(1'b0, 1'b1, 1'b0, 1'b1);
    // held press forces a stop once, its release does nothing
    repeat (6) push_item(1'b0, 1'b0, 1'b0, 1'b1);
    push_item(1'b0, 1'b1, 1'b0, 1'b1);
    // motion start, playback finished, motion start again, packet stops it
    push_item(1'b0, 1'b1, 1'b1, 1'b1);
    push_item(1'b0, 1'b1, 1'b1, 1'b0);
    push_item(1'b0, 1'b1, 1'b0, 1'b1);
    push_item(1'b0, 1'b1, 1'b1, 1'b1);
    push_item(1'b1, 1'b1, 1'b0, 1'b1);
    push_item(1'b0, 1'b0, 1'b1, 1'b1);
    wait_idle();

    hold_at = items_taken + 60;
    program_regs(20'd0, 20'd0, 20'd0, 20'd0, 20'd0);
    gen_ticks(120);
    wait_idle();

    repeat (5) begin
      program_regs(20'($urandom_range(0, 25)),
                   {4'($urandom), 16'($urandom_range(0, 4))},
                   {4'($urandom), 16'($urandom_range(0, 12))},
                   20'($urandom_range(0, 40)),
                   {19'($urandom), 1'($urandom_range(0, 3) != 0)});
      gen_ticks(125);
      wait_idle();
    end

    program_regs(CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES);
    gen_ticks(120);
    wait_idle();

    program_regs(20'($urandom_range(0, 25)), 20'd1, 20'd6, 20'd15, 20'd1);
    gen_ticks(125);
    wait_idle();

    $display("checked %0d tick words across %0d register settings", results_checked,
             settings_used);
    $display("saw %0d start and %0d stop requests, %0d ticks under network control",
             starts_seen, stops_seen, net_ticks);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
